// ----- design/csvt_pkg.sv -----
// ---------------------------------------------------------------------------
// csvt_pkg: shared types and constants for the CSV field tokenizer
// Payload structs, result codes and the whitespace test.
// ---------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

    localparam int CU_BITS = 16;

    localparam logic [CU_BITS-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CU_BITS-1:0] CH_LF    = 16'h000A;
    localparam logic [CU_BITS-1:0] CH_CR    = 16'h000D;
    localparam logic [CU_BITS-1:0] DELIM_RESET = 16'h003B;

    localparam logic [2:0] K_CHAR  = 3'd0;
    localparam logic [2:0] K_FIELD = 3'd1;
    localparam logic [2:0] K_ROW   = 3'd2;
    localparam logic [2:0] K_ERROR = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_QUOTE    = 2'd1;
    localparam logic [1:0] ST_AFTER    = 2'd2;
    localparam logic [1:0] ST_UNCLOSED = 2'd3;

    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [CU_BITS-1:0] code_unit;
        logic               end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [CU_BITS-1:0] out_char;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [CU_BITS-1:0] ch;
        logic [1:0]         status;
    } t_res;

    // all results of one input item; cnt counts the used slots
    typedef struct packed {
        logic [1:0]              cnt;
        t_res [MAX_RES-1:0]      res;
    } t_bundle;

    function automatic logic is_space(input logic [CU_BITS-1:0] c);
        return c inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0,
                         16'h1680, [16'h2000:16'h200A], 16'h2028, 16'h2029,
                         16'h202F, 16'h205F, 16'h3000};
    endfunction

    function automatic t_bundle add_res(input t_bundle b, input logic [2:0] kind,
                                        input logic [CU_BITS-1:0] ch,
                                        input logic [1:0] status);
        t_bundle r;
        r = b;
        if (b.cnt != 2'd3) begin
            r.res[b.cnt].kind   = kind;
            r.res[b.cnt].ch     = (kind == K_CHAR) ? ch : '0;
            r.res[b.cnt].status = status;
            r.cnt               = b.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/csvt_front.sv -----
// ---------------------------------------------------------------------------
// csvt_front: quoting state machine of the CSV field tokenizer
// Accepts one code unit a cycle unless the queue is full, updates the text
// state, and pushes the beat's results as one bundle into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [csvt_pkg::CU_BITS-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    input  wire csvt_pkg::t_in_item          i_in_data,
    output logic                             o_in_stall,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output csvt_pkg::t_bundle                o_push_data
);
    import csvt_pkg::*;

    logic [CU_BITS-1:0] r_delim;
    logic r_in_quotes, r_quote_pending, r_after_close;
    logic r_field_nonempty, r_row_nonempty, r_held_cr;
    logic [1:0] r_error;

    logic n_in_quotes, n_quote_pending, n_after_close;
    logic n_field_nonempty, n_row_nonempty, n_held_cr;
    logic [1:0] n_error;
    t_bundle bund;
    logic accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic [CU_BITS-1:0] c;
        logic [CU_BITS-1:0] app_c;
        logic [1:0] final_st;
        logic do_unq;
        logic do_app;
        logic [1:0] err_code;
        logic do_err;

        c        = i_in_data.code_unit;
        app_c    = c;
        final_st = r_error;
        do_unq   = 1'b0;
        do_app   = 1'b0;
        do_err   = 1'b0;
        err_code = ST_OK;
        bund     = '0;

        n_in_quotes      = r_in_quotes;
        n_quote_pending  = r_quote_pending;
        n_after_close    = r_after_close;
        n_field_nonempty = r_field_nonempty;
        n_row_nonempty   = r_row_nonempty;
        n_held_cr        = r_held_cr;
        n_error          = r_error;

        if (i_in_data.end_of_text) begin
            if (r_error == ST_OK) begin
                if (r_in_quotes && !r_quote_pending) begin
                    bund     = add_res(bund, K_ERROR, '0, ST_UNCLOSED);
                    final_st = ST_UNCLOSED;
                end else begin
                    // pending quote closes the field
                    if (r_held_cr) begin
                        bund = add_res(bund, K_CHAR, CH_CR, ST_OK);
                    end
                    if (r_field_nonempty || r_row_nonempty || r_after_close ||
                        r_quote_pending) begin
                        bund = add_res(bund, K_ROW, '0, ST_OK);
                    end
                end
            end
            bund             = add_res(bund, K_DONE, '0, final_st);
            n_in_quotes      = 1'b0;
            n_quote_pending  = 1'b0;
            n_after_close    = 1'b0;
            n_field_nonempty = 1'b0;
            n_row_nonempty   = 1'b0;
            n_held_cr        = 1'b0;
            n_error          = ST_OK;
        end else if (r_error == ST_OK) begin
            if (r_in_quotes) begin
                if (r_quote_pending) begin
                    n_quote_pending = 1'b0;
                    if (c == CH_QUOTE) begin
                        do_app = 1'b1;
                    end else begin
                        n_in_quotes   = 1'b0;
                        n_after_close = 1'b1;
                        do_unq        = 1'b1;
                    end
                end else if (c == CH_QUOTE) begin
                    n_quote_pending = 1'b1;
                end else begin
                    do_app = 1'b1;
                end
            end else begin
                do_unq = 1'b1;
            end

            if (do_unq) begin
                if (c == CH_QUOTE) begin
                    if (n_field_nonempty || n_after_close) begin
                        do_err   = 1'b1;
                        err_code = ST_QUOTE;
                    end else begin
                        n_in_quotes = 1'b1;
                    end
                end else if (c == CH_LF) begin
                    // drop a held CR before LF
                    n_held_cr        = 1'b0;
                    bund             = add_res(bund, K_ROW, '0, ST_OK);
                    n_field_nonempty = 1'b0;
                    n_after_close    = 1'b0;
                    n_row_nonempty   = 1'b0;
                end else if (c == r_delim) begin
                    if (n_held_cr) begin
                        bund = add_res(bund, K_CHAR, CH_CR, ST_OK);
                    end
                    n_held_cr        = 1'b0;
                    bund             = add_res(bund, K_FIELD, '0, ST_OK);
                    n_field_nonempty = 1'b0;
                    n_after_close    = 1'b0;
                    n_row_nonempty   = 1'b1;
                end else if (n_after_close) begin
                    if (!is_space(c)) begin
                        do_err   = 1'b1;
                        err_code = ST_AFTER;
                    end
                end else begin
                    do_app = 1'b1;
                end
            end

            if (do_app) begin
                if (n_held_cr) begin
                    bund = add_res(bund, K_CHAR, CH_CR, ST_OK);
                end
                n_held_cr = 1'b0;
                if (app_c == CH_CR) begin
                    n_held_cr = 1'b1;
                end else begin
                    bund = add_res(bund, K_CHAR, app_c, ST_OK);
                end
                n_field_nonempty = 1'b1;
            end

            if (do_err) begin
                n_error         = err_code;
                n_held_cr       = 1'b0;
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                bund            = add_res(bund, K_ERROR, '0, err_code);
            end
        end
    end

    assign o_push      = accept && (bund.cnt != 2'd0);
    assign o_push_data = bund;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim          <= DELIM_RESET;
            r_in_quotes      <= 1'b0;
            r_quote_pending  <= 1'b0;
            r_after_close    <= 1'b0;
            r_field_nonempty <= 1'b0;
            r_row_nonempty   <= 1'b0;
            r_held_cr        <= 1'b0;
            r_error          <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_delim <= i_cfg_data;
            end
            if (accept) begin
                r_in_quotes      <= n_in_quotes;
                r_quote_pending  <= n_quote_pending;
                r_after_close    <= n_after_close;
                r_field_nonempty <= n_field_nonempty;
                r_row_nonempty   <= n_row_nonempty;
                r_held_cr        <= n_held_cr;
                r_error          <= n_error;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/csvt_queue.sv -----
// ---------------------------------------------------------------------------
// csvt_queue: result bundle queue of the CSV field tokenizer
// Small FIFO that decouples the state machine from the output serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire csvt_pkg::t_bundle  i_push_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output csvt_pkg::t_bundle       o_data
);
    import csvt_pkg::*;

    t_bundle r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr, r_rd;
    logic [Q_PTR_BITS:0]   r_count;
    logic do_pop;

    assign o_full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_BITS'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (Q_PTR_BITS+1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (Q_PTR_BITS+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/csvt_back.sv -----
// ---------------------------------------------------------------------------
// csvt_back: output serializer of the CSV field tokenizer
// Holds one bundle and hands out its results one beat at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire csvt_pkg::t_bundle  i_q_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output csvt_pkg::t_out_item     o_out_data,
    input  wire logic               i_out_stall
);
    import csvt_pkg::*;

    t_bundle    r_bund;
    logic       r_have;
    logic [1:0] r_idx;
    logic fire, is_last, load;

    assign fire    = r_have && !i_out_stall;
    assign is_last = (r_idx == r_bund.cnt - 2'd1);
    assign load    = !r_have || (fire && is_last);
    assign o_pop   = load && i_q_valid;

    assign o_out_valid         = r_have;
    assign o_out_data.kind     = r_bund.res[r_idx].kind;
    assign o_out_data.out_char = r_bund.res[r_idx].ch;
    assign o_out_data.status   = r_bund.res[r_idx].status;
    assign o_out_data.last     = is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bund <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_have <= i_q_valid;
            r_idx  <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- design/csv_field_tokenizer_top.sv -----
// ---------------------------------------------------------------------------
// csv_field_tokenizer_top: streaming tokenizer for quoted delimited text
// Path: a beat's results are written into the bundle queue and then loaded
// into the serializer's bundle register, which drives the result port.
// Throughput: one input beat per cycle while the four-entry bundle queue has
// room; results leave at one per cycle while the output is not stalled, and
// that output port sets the sustained rate.
// Reset: synchronous, active low; clears the text state and the queue and
// sets the delimiter to ';' (0x3B).
// ---------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [csvt_pkg::CU_BITS-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire csvt_pkg::t_in_item           i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output csvt_pkg::t_out_item               o_out_data,
    input  wire logic                         i_out_stall
);
    import csvt_pkg::*;

    // front to queue: one bundle per beat that has any result
    logic    q_push, q_full, q_pop, q_valid;
    t_bundle q_push_data, q_data;

    // Front: classify each code unit against quote, LF and delimiter and
    // advance the quoting state. It stalls only when the queue is full.
    csvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Queue: hold bundles so input and output stall on their own.
    csvt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // Back: split each bundle into result beats, flag the last one.
    csvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- design/csvt_checker.sv -----
// ---------------------------------------------------------------------------
// csvt_checker: port-level checks for the CSV field tokenizer
// Watches the result channel and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire csvt_pkg::t_out_item o_out_data,
    input wire logic                i_out_stall
);
    import csvt_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // the done result always closes the results of its beat
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == K_DONE |-> o_out_data.last)
        else $error("done result without last");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != K_CHAR |-> o_out_data.out_char == '0)
        else $error("character on a non-character result");

    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == K_CHAR || o_out_data.kind == K_FIELD ||
                        o_out_data.kind == K_ROW) |-> o_out_data.status == ST_OK)
        else $error("status set on a field result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind csv_field_tokenizer_top csvt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CSV field tokenizer
// Drives code-unit beats from a queue, predicts every token in step with the
// accepted beats, and checks each output beat against the oldest prediction
// under several delimiter settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csvt_pkg::*;

    // Give up after this many cycles without a beat on either channel.
    localparam int WATCHDOG_LIMIT = 2000;
    // Random beats per delimiter phase; nine phases and the directed texts
    // land near 420 beats.
    localparam int PHASE_BEATS = 35;
    // Quiet cycles to let a beat without tokens drain through the block.
    localparam int DRAIN_CYCLES = 10;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [CU_BITS-1:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    t_in_item   in_beat  = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_beat;
    logic       out_stall = 1'b0;

    csv_field_tokenizer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_beat),
        .i_out_stall (out_stall)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Token predictor: its own copy of the quoting state and the delimiter.
    // ------------------------------------------------------------------------
    logic [CU_BITS-1:0] delim_cfg = DELIM_RESET;
    logic       in_quote;        // inside a quoted field
    logic       quote_seen;      // quote inside quotes: doubled or closing?
    logic       closed_quote;    // quoted field closed, field not yet ended
    logic       field_has_text;  // field holds text, a held CR included
    logic       row_has_fields;  // row already holds an ended field
    logic       cr_held;         // CR waiting to be released or dropped
    logic [1:0] text_error;      // error of the current text

    t_out_item  beat_tokens[$];      // tokens of the beat being predicted
    t_out_item  expected_tokens[$];  // tokens still owed by the block
    t_in_item   pending_beats[$];    // beats not yet presented
    int         beats_queued = 0;
    int         failures     = 0;
    int         src_idle_pct  = 0;
    int         sink_stall_pct = 0;

    function automatic void restart_text();
        in_quote       = 1'b0;
        quote_seen     = 1'b0;
        closed_quote   = 1'b0;
        field_has_text = 1'b0;
        row_has_fields = 1'b0;
        cr_held        = 1'b0;
        text_error     = ST_OK;
    endfunction

    // Cap at three tokens per beat, as the block does.
    function automatic void push_token(input logic [2:0] kind,
                                       input logic [CU_BITS-1:0] ch,
                                       input logic [1:0] st);
        t_out_item t;
        if (beat_tokens.size() < MAX_RES) begin
            t.kind     = kind;
            t.out_char = (kind == K_CHAR) ? ch : '0;
            t.status   = st;
            t.last     = 1'b0;
            beat_tokens.push_back(t);
        end
    endfunction

    function automatic void release_held_cr();
        if (cr_held) begin
            push_token(K_CHAR, CH_CR, ST_OK);
            cr_held = 1'b0;
        end
    endfunction

    // Hold a CR back; any other unit goes straight out as a field char.
    function automatic void add_text(input logic [CU_BITS-1:0] c);
        release_held_cr();
        if (c == CH_CR)
            cr_held = 1'b1;
        else
            push_token(K_CHAR, c, ST_OK);
        field_has_text = 1'b1;
    endfunction

    function automatic void flag_error(input logic [1:0] code);
        text_error = code;
        cr_held    = 1'b0;
        in_quote   = 1'b0;
        quote_seen = 1'b0;
        push_token(K_ERROR, '0, code);
    endfunction

    // One code unit seen outside quotes.
    function automatic void outside_unit(input logic [CU_BITS-1:0] c);
        logic blank;
        blank = (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h2000 && c <= 16'h200A) ||
                c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
                c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
                c == 16'h3000;
        if (c == CH_QUOTE) begin
            if (field_has_text || closed_quote)
                flag_error(ST_QUOTE);
            else
                in_quote = 1'b1;
        end else if (c == CH_LF) begin
            cr_held = 1'b0;
            push_token(K_ROW, '0, ST_OK);
            field_has_text = 1'b0;
            closed_quote   = 1'b0;
            row_has_fields = 1'b0;
        end else if (c == delim_cfg) begin
            release_held_cr();
            push_token(K_FIELD, '0, ST_OK);
            field_has_text = 1'b0;
            closed_quote   = 1'b0;
            row_has_fields = 1'b1;
        end else if (closed_quote) begin
            if (!blank)
                flag_error(ST_AFTER);
        end else begin
            add_text(c);
        end
    endfunction

    // Work out all tokens of one accepted beat and append them to the
    // expected store, with last set on the final one.
    function automatic void tokenize_beat(input t_in_item beat);
        logic [CU_BITS-1:0] c;
        logic [1:0]         final_st;
        t_out_item          t;
        c = beat.code_unit;
        beat_tokens.delete();
        if (beat.end_of_text) begin
            final_st = text_error;
            if (text_error == ST_OK) begin
                if (in_quote && !quote_seen) begin
                    flag_error(ST_UNCLOSED);
                    final_st = ST_UNCLOSED;
                end else begin
                    // a pending quote closes the field at end of text
                    if (quote_seen) begin
                        in_quote     = 1'b0;
                        quote_seen   = 1'b0;
                        closed_quote = 1'b1;
                    end
                    release_held_cr();
                    if (field_has_text || row_has_fields || closed_quote)
                        push_token(K_ROW, '0, ST_OK);
                end
            end
            push_token(K_DONE, '0, final_st);
            restart_text();
        end else if (text_error == ST_OK) begin
            if (in_quote) begin
                if (quote_seen) begin
                    quote_seen = 1'b0;
                    if (c == CH_QUOTE) begin
                        add_text(CH_QUOTE);
                    end else begin
                        in_quote     = 1'b0;
                        closed_quote = 1'b1;
                        outside_unit(c);
                    end
                end else if (c == CH_QUOTE) begin
                    quote_seen = 1'b1;
                end else begin
                    add_text(c);
                end
            end else begin
                outside_unit(c);
            end
        end
        foreach (beat_tokens[i]) begin
            t = beat_tokens[i];
            t.last = (i == beat_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued beats, idling at random between them. Hold a
    // stalled beat unchanged; predict each beat at the edge it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : driver
        logic took;
        took = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
            restart_text();
        end else begin
            if (took)
                tokenize_beat(in_beat);
            if (!in_valid || took) begin
                if (pending_beats.size() != 0 &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each taken output beat with the oldest prediction and
    // stall the output at random.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $display({"%0t: token with none expected: ",
                              "kind=%0d char=%h status=%0d last=%0d"},
                             $time, out_beat.kind, out_beat.out_char, out_beat.status,
                             out_beat.last);
                    failures <= failures + 1;
                end else begin
                    want = expected_tokens.pop_front();
                    if (out_beat.kind !== want.kind || out_beat.out_char !== want.out_char ||
                        out_beat.status !== want.status || out_beat.last !== want.last) begin
                        $display({"%0t: token mismatch: ",
                                  "expected kind=%0d char=%h status=%0d last=%0d, ",
                                  "got kind=%0d char=%h status=%0d last=%0d"},
                                 $time, want.kind, want.out_char, want.status, want.last,
                                 out_beat.kind, out_beat.out_char, out_beat.status,
                                 out_beat.last);
                        failures <= failures + 1;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a beat.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_unit(input logic [CU_BITS-1:0] c);
        t_in_item b;
        b.code_unit   = c;
        b.end_of_text = 1'b0;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // End of text carries a random code unit that the block must ignore.
    task automatic queue_end();
        t_in_item b;
        b.code_unit   = CU_BITS'($urandom);
        b.end_of_text = 1'b1;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [CU_BITS-1:0] pick_blank();
        int r;
        r = $urandom_range(0, 23);
        if (r < 11)
            return 16'h2000 + 16'(r);
        case (r)
            11: return 16'h0009;
            12: return 16'h000B;
            13: return 16'h000C;
            14: return 16'h000D;
            15: return 16'h0020;
            16: return 16'h0085;
            17: return 16'h00A0;
            18: return 16'h1680;
            19: return 16'h2028;
            20: return 16'h2029;
            21: return 16'h202F;
            22: return 16'h205F;
            default: return 16'h3000;
        endcase
    endfunction

    function automatic logic [CU_BITS-1:0] pick_letter();
        return 16'h0061 + 16'($urandom_range(0, 25));
    endfunction

    // Mixed content: letters, any 16-bit unit, blanks, CR, the delimiter,
    // quotes and LF.
    function automatic logic [CU_BITS-1:0] rand_unit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return pick_letter();
            4, 5:       return CU_BITS'($urandom);
            6:          return pick_blank();
            7:          return CH_CR;
            8:          return delim_cfg;
            default:    return $urandom_range(0, 1) ? CH_QUOTE : CH_LF;
        endcase
    endfunction

    // One text of 1..3 rows of 1..3 fields, quoted or bare, ended by end of
    // text. A nonzero flaw replaces one field: stray quote, text after a
    // closing quote, or a quote left open up to end of text.
    task automatic gen_text(input int flaw);
        int rows, fields, n, bad_row, bad_field;
        logic [CU_BITS-1:0] c;
        rows    = $urandom_range(1, 3);
        bad_row = $urandom_range(0, rows - 1);
        for (int r = 0; r < rows; r++) begin
            fields    = $urandom_range(1, 3);
            bad_field = $urandom_range(0, fields - 1);
            for (int f = 0; f < fields; f++) begin
                if (f > 0)
                    queue_unit(delim_cfg);
                n = $urandom_range(0, 4);
                if (flaw != 0 && r == bad_row && f == bad_field) begin
                    case (flaw)
                        1: begin
                            queue_unit(pick_letter());
                            queue_unit(CH_QUOTE);
                        end
                        2: begin
                            queue_unit(CH_QUOTE);
                            queue_unit(pick_letter());
                            queue_unit(CH_QUOTE);
                            queue_unit(pick_letter());
                        end
                        default: begin
                            queue_unit(CH_QUOTE);
                            queue_unit(pick_letter());
                            queue_end();
                            return;
                        end
                    endcase
                end else if ($urandom_range(0, 1)) begin
                    queue_unit(CH_QUOTE);
                    repeat (n) begin
                        c = rand_unit();
                        queue_unit(c);
                        if (c == CH_QUOTE)
                            queue_unit(c);   // double it to stay inside quotes
                    end
                    queue_unit(CH_QUOTE);
                    if ($urandom_range(0, 3) == 0)
                        queue_unit(pick_blank());
                end else begin
                    repeat (n) begin
                        do
                            c = rand_unit();
                        while (c == CH_QUOTE || c == CH_LF || c == delim_cfg);
                        queue_unit(c);
                    end
                end
            end
            if (r < rows - 1 || $urandom_range(0, 1)) begin
                if ($urandom_range(0, 2) == 0)
                    queue_unit(CH_CR);
                queue_unit(CH_LF);
            end
        end
        queue_end();
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 8))
            queue_unit($urandom_range(0, 3) == 0 ? CU_BITS'($urandom) : rand_unit());
        queue_end();
    endtask

    // Wait until every beat is taken and every token has come, then drain.
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One phase: optionally rewrite the delimiter while idle, pick the
    // idle/stall mix, then queue a batch of random texts.
    task automatic run_phase(input logic write, input logic [CU_BITS-1:0] delim,
                             input int mode);
        int start, r;
        wait_quiet();
        if (write) begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_data  <= delim;
            delim_cfg = delim;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
        @(negedge clk);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
            default: begin src_idle_pct = 36; sink_stall_pct = 36; end
        endcase
        start = beats_queued;
        while (beats_queued - start < PHASE_BEATS) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                gen_text(0);
            else if (r < 9)
                gen_text($urandom_range(1, 3));
            else
                gen_noise();
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset delimiter ';'. Quoted field with a delimiter
        // inside, a doubled quote, closing quote, blank after close, row end.
        queue_unit(16'h0061); queue_unit(DELIM_RESET); queue_unit(CH_QUOTE);
        queue_unit(DELIM_RESET); queue_unit(CH_QUOTE); queue_unit(CH_QUOTE);
        queue_unit(CH_QUOTE); queue_unit(16'h0020); queue_unit(CH_LF);
        // Lowest code unit, CR pushed out by a second CR, held CR dropped at LF.
        queue_unit(16'h0000); queue_unit(CH_CR); queue_unit(CH_CR); queue_unit(CH_LF);
        // Highest code unit, held CR released at end of text: three tokens.
        queue_unit(16'hFFFF); queue_unit(CH_CR); queue_end();
        // Stray quote, then an ignored unit up to end of text.
        queue_unit(16'h0064); queue_unit(CH_QUOTE); queue_unit(16'h007A); queue_end();
        // Text after a closing quote.
        queue_unit(CH_QUOTE); queue_unit(CH_QUOTE); queue_unit(16'h0071); queue_end();
        // Unclosed quote at end of text.
        queue_unit(CH_QUOTE); queue_unit(16'h0077); queue_end();
        // Quote pending at end of text closes the field.
        queue_unit(CH_QUOTE); queue_unit(16'h0061); queue_unit(CH_QUOTE); queue_end();
        // Empty text.
        queue_end();

        // Random phases; the delimiter walks through its extremes and the
        // units that quote and LF override.
        run_phase(1'b0, DELIM_RESET, 0);
        run_phase(1'b1, 16'h002C, 1);
        run_phase(1'b1, 16'h0000, 2);
        run_phase(1'b1, 16'hFFFF, 3);
        run_phase(1'b1, CH_QUOTE, 0);
        run_phase(1'b1, CH_LF, 1);
        run_phase(1'b1, CH_CR, 2);
        run_phase(1'b1, 16'h0020, 3);
        run_phase(1'b1, DELIM_RESET, 3);

        wait_quiet();
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
